// ----- hw/rtl/fpa_pkg.sv -----
// Shared types and constants for the fixed slot pool allocator.
// No dependencies; every other file of the block imports this package.
package fpa_pkg;

  localparam int unsigned DEF_MAX_SLOTS = 64;
  localparam int unsigned GROUP         = 8;
  localparam int unsigned QDEPTH        = 2;
  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned SLOT_W        = 16;
  localparam int unsigned COUNT_W       = 7;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_REALLOC = 2'd1,
    CMD_FREE    = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TOO_BIG = 2'd1,
    ST_NO_FREE = 2'd2,
    ST_OOB     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_BASE         = 2'd0,
    CFG_SLOT_BYTES   = 2'd1,
    CFG_SLOTS_IN_USE = 2'd2,
    CFG_NONE         = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [SLOT_W-1:0]  slot_bytes;
    logic [COUNT_W-1:0] slots_in_use;
  } cfg_t;

  // Classified command: addr holds the offset from base for free.
  typedef struct packed {
    cmd_t              cmd;
    logic              too_big;
    logic              oob;
    logic [ADDR_W-1:0] addr;
  } entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_MUL,
    BK_ADD,
    BK_DIV
  } back_state_t;

endpackage

// ----- hw/rtl/fpa_front.sv -----
// Front end: configuration registers, command acceptance and classification.
// Depends on fpa_pkg; feeds fpa_fifo.
module fpa_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [fpa_pkg::ADDR_W-1:0]  cfg_wdata,
  input  logic                        start,
  input  logic [1:0]                  in_command,
  input  logic [fpa_pkg::ADDR_W-1:0]  in_request_size,
  input  logic [fpa_pkg::ADDR_W-1:0]  in_block_address,
  input  logic                        q_full,
  output logic                        q_push,
  output fpa_pkg::entry_t             q_entry,
  output fpa_pkg::cfg_t               cfg
);
  import fpa_pkg::*;

  logic [ADDR_W-1:0]  base_r;
  logic [SLOT_W-1:0]  slot_bytes_r;
  logic [COUNT_W-1:0] slots_in_use_r;
  cmd_t               cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r         <= '0;
      slot_bytes_r   <= SLOT_W'(64);
      slots_in_use_r <= COUNT_W'(64);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BASE:         base_r         <= cfg_wdata;
        CFG_SLOT_BYTES:   slot_bytes_r   <= cfg_wdata[SLOT_W-1:0];
        CFG_SLOTS_IN_USE: slots_in_use_r <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = '{base: base_r, slot_bytes: slot_bytes_r, slots_in_use: slots_in_use_r};

  always_comb begin
    cmd             = cmd_t'(in_command);
    q_push          = start && !q_full;
    q_entry.cmd     = cmd;
    q_entry.too_big = in_request_size > {{(ADDR_W-SLOT_W){1'b0}}, slot_bytes_r};
    q_entry.oob     = (in_block_address < base_r) || (slot_bytes_r == '0);
    if (cmd == CMD_FREE) begin
      q_entry.addr = in_block_address - base_r;
    end else begin
      q_entry.addr = in_block_address;
    end
  end

endmodule

// ----- hw/rtl/fpa_fifo.sv -----
// Short command queue between front and back ends.
// Depends on fpa_pkg for the entry type.
module fpa_fifo #(
  parameter int unsigned DEPTH = fpa_pkg::QDEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fpa_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output fpa_pkg::entry_t head
);
  import fpa_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t          mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push;
  logic            do_pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/fpa_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
// Depends on fpa_pkg for widths; used by fpa_back for free.
module fpa_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [fpa_pkg::ADDR_W-1:0] dividend,
  input  logic [fpa_pkg::SLOT_W-1:0] divisor,
  output logic                       done,
  output logic [fpa_pkg::ADDR_W-1:0] quotient
);
  import fpa_pkg::*;

  localparam int unsigned NW = $clog2(ADDR_W);

  logic [ADDR_W-1:0] q_r;
  logic [SLOT_W-1:0] rem_r;
  logic [SLOT_W-1:0] div_r;
  logic [NW-1:0]     cnt_r;
  logic              run_r;
  logic              done_r;
  logic [SLOT_W:0]   rem_sh;
  logic [SLOT_W:0]   diff;
  logic              ge;

  assign rem_sh   = {rem_r, q_r[ADDR_W-1]};
  assign diff     = rem_sh - {1'b0, div_r};
  assign ge       = rem_sh >= {1'b0, div_r};
  assign done     = done_r;
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      div_r <= divisor;
      cnt_r <= '0;
    end else if (run_r) begin
      rem_r <= ge ? diff[SLOT_W-1:0] : rem_sh[SLOT_W-1:0];
      q_r   <= {q_r[ADDR_W-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        run_r  <= 1'b1;
        done_r <= 1'b0;
      end else if (run_r && cnt_r == NW'(ADDR_W - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end else begin
        done_r <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/fpa_back.sv -----
// Back end: free map, grouped slot scan, address multiply and result register.
// Depends on fpa_pkg and fpa_div; draws commands from fpa_fifo.
module fpa_back #(
  parameter int unsigned MAX_SLOTS = fpa_pkg::DEF_MAX_SLOTS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fpa_pkg::cfg_t              cfg,
  input  logic                       q_valid,
  input  fpa_pkg::entry_t            q_entry,
  output logic                       q_pop,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [fpa_pkg::ADDR_W-1:0] out_result_address
);
  import fpa_pkg::*;

  localparam int unsigned NG  = (MAX_SLOTS + GROUP - 1) / GROUP;
  localparam int unsigned GW  = (NG > 1) ? $clog2(NG) : 1;
  localparam int unsigned JW  = $clog2(GROUP);
  localparam int unsigned SW  = GW + JW;
  localparam int unsigned FW  = (1 << GW) * GROUP;
  localparam int unsigned CW  = $clog2(MAX_SLOTS + 1);
  localparam int unsigned PRW = SW + SLOT_W;

  back_state_t        state_r, state_nxt;
  logic [FW-1:0]      free_r;
  logic [GW-1:0]      grp_r, grp_nxt;
  logic [SW-1:0]      sidx_r, sidx_nxt;
  logic [PRW-1:0]     prod_r, prod_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            status_r, status_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [CW-1:0]      count;
  logic [GROUP-1:0]   grp_bits;
  logic [JW-1:0]      hit;
  logic               clr_en, set_en;
  logic [SW-1:0]      map_idx;
  logic               div_start, div_done;
  logic [ADDR_W-1:0]  div_quot;

  fpa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (q_entry.addr),
    .divisor  (cfg.slot_bytes),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    if (32'(cfg.slots_in_use) > 32'(MAX_SLOTS)) begin
      count = CW'(MAX_SLOTS);
    end else begin
      count = CW'(cfg.slots_in_use);
    end
  end

  always_comb begin
    hit = '0;
    for (int j = 0; j < GROUP; j++) begin
      grp_bits[j] = free_r[{grp_r, JW'(j)}] && (32'({grp_r, JW'(j)}) < 32'(count));
    end
    for (int j = GROUP - 1; j >= 0; j--) begin
      if (grp_bits[j]) begin
        hit = JW'(j);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    grp_nxt       = grp_r;
    sidx_nxt      = sidx_r;
    prod_nxt      = prod_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    addr_nxt      = addr_r;
    q_pop         = 1'b0;
    div_start     = 1'b0;
    clr_en        = 1'b0;
    set_en        = 1'b0;
    map_idx       = sidx_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_entry.cmd)
            CMD_ALLOC: begin
              if (q_entry.too_big) begin
                out_valid_nxt = 1'b1;
                status_nxt    = ST_TOO_BIG;
                addr_nxt      = '0;
              end else begin
                grp_nxt   = '0;
                state_nxt = BK_SCAN;
              end
            end
            CMD_REALLOC: begin
              out_valid_nxt = 1'b1;
              status_nxt    = q_entry.too_big ? ST_TOO_BIG : ST_OK;
              addr_nxt      = q_entry.too_big ? '0 : q_entry.addr;
            end
            CMD_FREE: begin
              if (q_entry.oob) begin
                out_valid_nxt = 1'b1;
                status_nxt    = ST_OOB;
                addr_nxt      = '0;
              end else begin
                div_start = 1'b1;
                state_nxt = BK_DIV;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              status_nxt    = ST_OK;
              addr_nxt      = '0;
            end
          endcase
        end
      end
      BK_SCAN: begin
        if (|grp_bits) begin
          sidx_nxt  = {grp_r, hit};
          map_idx   = {grp_r, hit};
          clr_en    = 1'b1;
          state_nxt = BK_MUL;
        end else if (grp_r == GW'(NG - 1)) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_NO_FREE;
          addr_nxt      = '0;
          state_nxt     = BK_IDLE;
        end else begin
          grp_nxt = grp_r + 1'b1;
        end
      end
      BK_MUL: begin
        prod_nxt  = PRW'(sidx_r) * PRW'(cfg.slot_bytes);
        state_nxt = BK_ADD;
      end
      BK_ADD: begin
        out_valid_nxt = 1'b1;
        status_nxt    = ST_OK;
        addr_nxt      = cfg.base + ADDR_W'(prod_r);
        state_nxt     = BK_IDLE;
      end
      BK_DIV: begin
        if (div_done) begin
          out_valid_nxt = 1'b1;
          addr_nxt      = '0;
          state_nxt     = BK_IDLE;
          if (div_quot >= ADDR_W'(count)) begin
            status_nxt = ST_OOB;
          end else begin
            status_nxt = ST_OK;
            map_idx    = div_quot[SW-1:0];
            set_en     = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      free_r      <= '1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (clr_en) begin
        free_r[map_idx] <= 1'b0;
      end else if (set_en) begin
        free_r[map_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_r    <= grp_nxt;
    sidx_r   <= sidx_nxt;
    prod_r   <= prod_nxt;
    status_r <= status_nxt;
    addr_r   <= addr_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_result_address = addr_r;

endmodule

// ----- hw/rtl/fixed_slot_pool_allocator.sv -----
// Top level of the fixed slot pool allocator: front end, command queue, back end.
// Depends on fpa_pkg, fpa_front, fpa_fifo, fpa_back (which holds fpa_div).
//
//   channel  handshake            payload
//   in       start / busy         in_command, in_request_size, in_block_address
//   out      out_valid (1 cycle)  out_status, out_result_address
//   cfg      cfg_we               cfg_index, cfg_wdata
//
// Allocate scans the free map eight slots a cycle, then does one multiply and one
// add. Free runs the serial divider to turn the offset into a slot index;
// reallocate, rejected and unused commands are answered from the idle state.
// A two-entry queue lets start be taken while the back end works; busy is high
// only while it is full. Reset is synchronous and marks every slot free.
// The receiver cannot stall: each transfer is shown for one cycle only.
module fixed_slot_pool_allocator #(
  parameter int unsigned MAX_SLOTS = fpa_pkg::DEF_MAX_SLOTS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [fpa_pkg::ADDR_W-1:0] cfg_wdata,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_command,
  input  logic [fpa_pkg::ADDR_W-1:0] in_request_size,
  input  logic [fpa_pkg::ADDR_W-1:0] in_block_address,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [fpa_pkg::ADDR_W-1:0] out_result_address
);
  import fpa_pkg::*;

  logic   q_full;
  logic   q_push;
  logic   q_pop;
  logic   q_valid;
  entry_t q_in;
  entry_t q_head;
  cfg_t   cfg;

  assign busy = q_full;

  fpa_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .start            (start),
    .in_command       (in_command),
    .in_request_size  (in_request_size),
    .in_block_address (in_block_address),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_entry          (q_in),
    .cfg              (cfg)
  );

  fpa_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_valid),
    .head       (q_head)
  );

  fpa_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .q_valid            (q_valid),
    .q_entry            (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_result_address (out_result_address)
  );

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for fixed_slot_pool_allocator: directed and random commands
// checked against a slot free-map predictor held in a small scoreboard class.
// Depends on fpa_pkg and the fixed_slot_pool_allocator RTL; needs nothing else.
module testbench;
  import fpa_pkg::*;

  localparam int unsigned N_SLOTS    = DEF_MAX_SLOTS;
  localparam int unsigned CYCLE_CAP  = 400000;
  localparam int unsigned SETTLE     = 8;
  localparam int unsigned N_PHASES   = 8;
  localparam int unsigned PHASE_ITEMS = 75;

  typedef struct {
    status_t     status;
    logic [31:0] addr;
  } pool_result_t;

  class slot_pool_scoreboard;
    logic [31:0]  base;
    logic [15:0]  slot_sz;
    logic [6:0]   slot_cnt;
    bit           slot_free [N_SLOTS];
    pool_result_t pending_results [$];
    logic [31:0]  live_blocks [$];
    int           errors;

    function new();
      base     = '0;
      slot_sz  = 16'd64;
      slot_cnt = 7'd64;
      foreach (slot_free[k]) slot_free[k] = 1'b1;
      errors   = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] val);
      case (idx)
        CFG_BASE:         base     = val;
        CFG_SLOT_BYTES:   slot_sz  = val[15:0];
        CFG_SLOTS_IN_USE: slot_cnt = val[6:0];
        default: ;
      endcase
    endfunction

    function int unsigned managed();
      return (slot_cnt > N_SLOTS) ? N_SLOTS : int'(slot_cnt);
    endfunction

    function void note_command(cmd_t cmd, logic [31:0] size, logic [31:0] addr);
      pool_result_t r;
      logic [31:0]  idx;
      int unsigned  count;
      bit           found;
      count    = managed();
      r.status = ST_OK;
      r.addr   = '0;
      found    = 1'b0;
      case (cmd)
        CMD_ALLOC: begin
          if (size > {16'h0, slot_sz}) begin
            r.status = ST_TOO_BIG;
          end else begin
            r.status = ST_NO_FREE;
            for (int unsigned k = 0; k < count; k++) begin
              if (!found && slot_free[k]) begin
                found        = 1'b1;
                slot_free[k] = 1'b0;
                r.addr       = base + 32'(k) * {16'h0, slot_sz};
                r.status     = ST_OK;
                live_blocks.push_back(r.addr);
              end
            end
          end
        end
        CMD_REALLOC: begin
          if (size > {16'h0, slot_sz}) r.status = ST_TOO_BIG;
          else r.addr = addr;
        end
        CMD_FREE: begin
          if (addr < base || slot_sz == 16'h0) begin
            r.status = ST_OOB;
          end else begin
            idx = (addr - base) / {16'h0, slot_sz};
            if (idx >= 32'(count)) r.status = ST_OOB;
            else slot_free[idx] = 1'b1;
          end
        end
        default: ;
      endcase
      pending_results.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 25) $display("mismatch %0d at %0t: %s", errors, $realtime, msg);
    endtask

    task check_response(logic [1:0] status, logic [31:0] addr);
      pool_result_t r;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer status %0d addr %h", status, addr));
      end else begin
        r = pending_results.pop_front();
        if (status_t'(status) != r.status)
          report_mismatch($sformatf("status %0d, expected %s", status, r.status.name()));
        if (addr !== r.addr)
          report_mismatch($sformatf("address %h, expected %h", addr, r.addr));
      end
    endtask

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        start;
  logic        busy;
  logic [1:0]  in_command;
  logic [31:0] in_request_size;
  logic [31:0] in_block_address;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_result_address;

  slot_pool_scoreboard sb;
  int unsigned n_accepted;
  int unsigned cycles;

  fixed_slot_pool_allocator #(.MAX_SLOTS(N_SLOTS)) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_request_size    (in_request_size),
    .in_block_address   (in_block_address),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_result_address (out_result_address)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    sb = new();
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.set_reg(cfg_idx_t'(cfg_index), cfg_wdata);
      if (start && !busy) begin
        sb.note_command(cmd_t'(in_command), in_request_size, in_block_address);
        n_accepted++;
      end
      if (out_valid) sb.check_response(out_status, out_result_address);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_CAP) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic send_item(cmd_t cmd, logic [31:0] size, logic [31:0] addr);
    int unsigned seen;
    seen             = n_accepted;
    start            = 1'b1;
    in_command       = cmd;
    in_request_size  = size;
    in_block_address = addr;
    do @(negedge clk); while (n_accepted == seen);
  endtask

  task automatic idle_for(int unsigned n);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    wait_drained();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic send_random_item();
    int unsigned pick;
    int unsigned j;
    logic [31:0] size;
    logic [31:0] addr;
    pick = $urandom_range(0, 99);
    size = $urandom_range(0, int'(sb.slot_sz));
    addr = $urandom;
    if (pick < 40) begin
      send_item(CMD_ALLOC, size, addr);
    end else if (pick < 48) begin
      send_item(CMD_ALLOC, $urandom, addr);
    end else if (pick < 58) begin
      if ($urandom_range(0, 2) == 0) size = $urandom;
      if (sb.live_blocks.size() != 0 && $urandom_range(0, 1) == 0)
        addr = sb.live_blocks[$urandom_range(0, sb.live_blocks.size() - 1)];
      send_item(CMD_REALLOC, size, addr);
    end else if (pick < 88 && sb.live_blocks.size() != 0) begin
      j    = $urandom_range(0, sb.live_blocks.size() - 1);
      addr = sb.live_blocks[j];
      sb.live_blocks.delete(j);
      if (sb.slot_sz != 0 && $urandom_range(0, 2) == 0)
        addr = addr + $urandom_range(0, int'(sb.slot_sz) - 1);
      send_item(CMD_FREE, $urandom, addr);
    end else if (pick < 95) begin
      if ($urandom_range(0, 1) == 0)
        addr = sb.base + 32'($urandom_range(0, sb.managed() + 2)) * {16'h0, sb.slot_sz};
      send_item(CMD_FREE, $urandom, addr);
    end else begin
      send_item(CMD_UNUSED, $urandom, addr);
    end
  endtask

  task automatic run_directed();
    send_item(CMD_ALLOC,   32'd0,        32'hFFFF_FFFF);
    send_item(CMD_ALLOC,   32'd64,       32'd0);
    send_item(CMD_ALLOC,   32'd65,       32'd0);
    send_item(CMD_ALLOC,   32'hFFFF_FFFF, 32'd0);
    send_item(CMD_REALLOC, 32'd64,       32'hFFFF_FFFF);
    send_item(CMD_REALLOC, 32'd65,       32'h1234_5678);
    send_item(CMD_FREE,    32'd0,        32'd69);
    send_item(CMD_FREE,    32'hFFFF_FFFF, 32'd64);
    send_item(CMD_FREE,    32'd0,        32'd4096);
    send_item(CMD_FREE,    32'd0,        32'hFFFF_FFFF);
    send_item(CMD_UNUSED,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_reg(CFG_BASE,         32'hFFFF_FFC0);
    write_reg(CFG_SLOT_BYTES,   32'h0000_FFFF);
    write_reg(CFG_SLOTS_IN_USE, 32'd2);
    send_item(CMD_ALLOC,   32'h0000_FFFF, 32'd0);
    send_item(CMD_ALLOC,   32'd1,        32'd0);
    send_item(CMD_FREE,    32'd0,        32'd0);
    send_item(CMD_FREE,    32'd0,        32'hFFFF_FFFF);
    write_reg(CFG_SLOT_BYTES,   32'd0);
    send_item(CMD_ALLOC,   32'd0,        32'd0);
    send_item(CMD_ALLOC,   32'd1,        32'd0);
    send_item(CMD_FREE,    32'd0,        32'hFFFF_FFC0);
    write_reg(CFG_SLOT_BYTES,   32'd16);
    write_reg(CFG_SLOTS_IN_USE, 32'd0);
    send_item(CMD_ALLOC,   32'd16,       32'd0);
    send_item(CMD_FREE,    32'd0,        32'hFFFF_FFC0);
    write_reg(CFG_BASE,         32'd0);
    write_reg(CFG_SLOTS_IN_USE, 32'd127);
    send_item(CMD_ALLOC,   32'd3,        32'd0);
    send_item(CMD_FREE,    32'd0,        32'd1023);
    send_item(CMD_FREE,    32'd0,        32'd1024);
  endtask

  task automatic configure_phase(int unsigned phase);
    logic [31:0] base;
    logic [31:0] slot;
    logic [31:0] count;
    case ($urandom_range(0, 3))
      0:       base = 32'd0;
      1:       base = $urandom;
      2:       base = 32'hFFFF_FFFF - $urandom_range(0, 4096);
      default: base = $urandom & 32'hFFFF_0000;
    endcase
    case ($urandom_range(0, 3))
      0:       slot = 32'd1;
      1:       slot = 32'h0000_FFFF;
      2:       slot = $urandom_range(1, 256);
      default: slot = $urandom_range(1, 65535);
    endcase
    case ($urandom_range(0, 3))
      0:       count = 32'd1;
      1:       count = 32'd64;
      2:       count = $urandom_range(1, 16);
      default: count = $urandom_range(65, 127);
    endcase
    if (phase == 0) begin
      base  = 32'd0;
      slot  = 32'd1;
      count = 32'd1;
    end else if (phase == 1) begin
      base  = 32'hFFFF_FFFF;
      slot  = 32'h0000_FFFF;
      count = 32'd64;
    end
    write_reg(CFG_BASE,         base);
    write_reg(CFG_SLOT_BYTES,   slot);
    write_reg(CFG_SLOTS_IN_USE, count);
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_NONE;
    cfg_wdata        = '0;
    start            = 1'b0;
    in_command       = CMD_ALLOC;
    in_request_size  = '0;
    in_block_address = '0;
    n_accepted       = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    run_directed();

    for (int unsigned phase = 0; phase < N_PHASES; phase++) begin
      configure_phase(phase);
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        if (phase < N_PHASES - 2) begin
          if ($urandom_range(0, 3) == 0) idle_for($urandom_range(1, 15));
          if ($urandom_range(0, 99) < 3) wait_drained();
        end
        send_random_item();
      end
    end

    wait_drained();
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ----- fixed_slot_pool_allocator.f -----
hw/rtl/fpa_pkg.sv
hw/rtl/fpa_front.sv
hw/rtl/fpa_fifo.sv
hw/rtl/fpa_div.sv
hw/rtl/fpa_back.sv
hw/rtl/fixed_slot_pool_allocator.sv
test/testbench.sv
